FILE: rtl/las_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, register indexes and compare-value constants for the
// launcher actuator sequencer.
// ----------------------------------------------------------------------------
package las_pkg;

    localparam int unsigned PWM_W   = 11;
    localparam int unsigned GATE_W  = 12;
    localparam int unsigned TRIGA_W = 10;
    localparam int unsigned TRIGB_W = 11;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned PHASE_W = 10;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 11;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SMALL_SPEED = 3'd0,
        CFG_BIG_SPEED   = 3'd1,
        CFG_FEED_ON     = 3'd2,
        CFG_BURST_PER   = 3'd3,
        CFG_BURST_ON    = 3'd4
    } t_cfg_idx;

    localparam logic [PWM_W-1:0]   PWM_MIN       = 11'd1000;
    localparam logic [PWM_W-1:0]   PWM_MAX       = 11'd2000;
    localparam logic [GATE_W-1:0]  GATE_SMALL    = 12'd1000;
    localparam logic [GATE_W-1:0]  GATE_LARGE    = 12'd2400;
    localparam logic [GATE_W-1:0]  GATE_RESET    = 12'd1500;
    localparam logic [TRIGA_W-1:0] TRIGA_LOW     = 10'd700;
    localparam logic [TRIGA_W-1:0] TRIGA_HIGH    = 10'd1000;
    localparam logic [TRIGB_W-1:0] TRIGB_LOW     = 11'd1500;
    localparam logic [TRIGB_W-1:0] TRIGB_HIGH    = 11'd2000;

    localparam logic [PHASE_W-1:0] PHASE_1       = 10'd25;
    localparam logic [PHASE_W-1:0] PHASE_2       = 10'd50;
    localparam logic [PHASE_W-1:0] PHASE_3       = 10'd80;
    localparam logic [PHASE_W-1:0] PHASE_DONE    = 10'd105;
    localparam logic [PHASE_W-1:0] PHASE_LIMIT   = 10'd1000;
    localparam logic [PHASE_W-1:0] PHASE_REWIND  = 10'd500;

    localparam logic [PWM_W-1:0]   RST_SMALL_SPD = 11'd2000;
    localparam logic [PWM_W-1:0]   RST_BIG_SPD   = 11'd1300;
    localparam logic [PWM_W-1:0]   RST_FEED_ON   = 11'd1150;
    localparam logic [CNT_W-1:0]   RST_BURST_PER = 8'd18;
    localparam logic [CNT_W-1:0]   RST_BURST_ON  = 8'd10;

    function automatic logic [PWM_W-1:0] las_clamp(input logic [PWM_W-1:0] v);
        if (v < PWM_MIN) begin
            return PWM_MIN;
        end else if (v > PWM_MAX) begin
            return PWM_MAX;
        end
        return v;
    endfunction

endpackage

FILE: rtl/las_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_ifs
// Valid/ready channels for switch beats in and compare-value beats out.
// ----------------------------------------------------------------------------
interface las_in_if;
    logic valid;
    logic ready;
    logic stop_switch;
    logic spin_small_switch;
    logic spin_large_switch;
    logic feed_off_switch;
    logic feed_burst_switch;
    logic rearm_switch;

    modport source (
        output valid, stop_switch, spin_small_switch, spin_large_switch,
               feed_off_switch, feed_burst_switch, rearm_switch,
        input  ready
    );
    modport sink (
        input  valid, stop_switch, spin_small_switch, spin_large_switch,
               feed_off_switch, feed_burst_switch, rearm_switch,
        output ready
    );
endinterface

interface las_out_if;
    import las_pkg::*;
    logic               valid;
    logic               ready;
    logic [PWM_W-1:0]   small_wheel_pwm;
    logic [PWM_W-1:0]   big_wheel_pwm;
    logic [PWM_W-1:0]   feeder_pwm;
    logic [GATE_W-1:0]  gate_pwm;
    logic [TRIGA_W-1:0] trigger_a_pwm;
    logic [TRIGB_W-1:0] trigger_b_pwm;
    logic               ready_flag;
    logic               wheels_running;

    modport source (
        output valid, small_wheel_pwm, big_wheel_pwm, feeder_pwm, gate_pwm,
               trigger_a_pwm, trigger_b_pwm, ready_flag, wheels_running,
        input  ready
    );
    modport sink (
        input  valid, small_wheel_pwm, big_wheel_pwm, feeder_pwm, gate_pwm,
               trigger_a_pwm, trigger_b_pwm, ready_flag, wheels_running,
        output ready
    );
endinterface

FILE: rtl/launcher_actuator_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// launcher_actuator_sequencer
// Applies one beat of switch flags per tick to the friction, feeder, gate and
// trigger state and returns the held compare values after the update.
// ----------------------------------------------------------------------------
// Path: an input beat is captured in the input register, then its result in
//   the state/result register.
// Throughput: 1 beat per cycle while the output is taken; the input register
//   holds one beat while a result waits on the output.
// Reset: synchronous, active low; state and config return to their defaults.
module launcher_actuator_sequencer
    import las_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    las_in_if.sink            i_in,
    las_out_if.source         o_out
);

    // config
    logic [PWM_W-1:0] r_small_spd, r_big_spd, r_feed_on;
    logic [CNT_W-1:0] r_burst_per, r_burst_on;

    // input stage
    logic       r_in_valid;
    logic [5:0] r_sw;

    // state, also the result register
    logic               r_out_valid;
    logic               r_running, n_running;
    logic               r_ready, n_ready;
    logic [CNT_W-1:0]   r_burst, n_burst;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PWM_W-1:0]   r_small, n_small;
    logic [PWM_W-1:0]   r_big, n_big;
    logic [PWM_W-1:0]   r_feeder, n_feeder;
    logic [GATE_W-1:0]  r_gate, n_gate;
    logic [TRIGA_W-1:0] r_trig_a, n_trig_a;
    logic [TRIGB_W-1:0] r_trig_b, n_trig_b;

    logic adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_spd <= RST_SMALL_SPD;
            r_big_spd   <= RST_BIG_SPD;
            r_feed_on   <= RST_FEED_ON;
            r_burst_per <= RST_BURST_PER;
            r_burst_on  <= RST_BURST_ON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SMALL_SPEED: r_small_spd <= i_cfg_data;
                CFG_BIG_SPEED:   r_big_spd   <= i_cfg_data;
                CFG_FEED_ON:     r_feed_on   <= i_cfg_data;
                CFG_BURST_PER:   r_burst_per <= i_cfg_data[CNT_W-1:0];
                CFG_BURST_ON:    r_burst_on  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sw <= {i_in.rearm_switch, i_in.feed_burst_switch, i_in.feed_off_switch,
                     i_in.spin_large_switch, i_in.spin_small_switch, i_in.stop_switch};
        end
    end

    always_comb begin
        logic [CNT_W:0]     v_inc;
        logic [PHASE_W-1:0] v_ph;
        n_running = r_running;
        n_ready   = r_ready;
        n_burst   = r_burst;
        n_phase   = r_phase;
        n_small   = r_small;
        n_big     = r_big;
        n_feeder  = r_feeder;
        n_gate    = r_gate;
        n_trig_a  = r_trig_a;
        n_trig_b  = r_trig_b;
        v_inc     = '0;
        v_ph      = '0;

        if (r_sw[0]) begin
            n_small   = PWM_MIN;
            n_big     = PWM_MIN;
            n_gate    = GATE_SMALL;
            n_running = 1'b0;
        end
        if (r_sw[1]) begin
            n_small   = las_clamp(r_small_spd);
            n_big     = las_clamp(r_big_spd);
            n_gate    = GATE_SMALL;
            n_running = 1'b1;
        end
        if (r_sw[2]) begin
            n_small   = las_clamp(r_small_spd);
            n_big     = las_clamp(r_big_spd);
            n_gate    = GATE_LARGE;
            n_running = 1'b1;
        end
        if (r_sw[3]) begin
            n_feeder = PWM_MIN;
            n_burst  = '0;
        end
        if (r_sw[4] && n_running) begin
            v_inc = {1'b0, n_burst} + 1'b1;
            if (v_inc > {1'b0, r_burst_per}) begin
                n_burst = '0;
            end else begin
                n_burst = v_inc[CNT_W-1:0];
            end
            n_feeder = (n_burst < r_burst_on) ? las_clamp(r_feed_on) : PWM_MIN;
        end
        if (r_sw[5] && n_running && n_ready) begin
            n_phase = '0;
            n_ready = 1'b0;
        end
        if (!n_ready) begin
            v_ph = n_phase + 1'b1;
            if (v_ph == PHASE_LIMIT) begin
                v_ph = PHASE_REWIND;
            end
            n_phase = v_ph;
            if (v_ph < PHASE_1) begin
                n_trig_a = TRIGA_LOW;
                n_trig_b = TRIGB_LOW;
            end else if (v_ph < PHASE_2) begin
                n_trig_a = TRIGA_LOW;
                n_trig_b = TRIGB_HIGH;
            end else if (v_ph < PHASE_3) begin
                n_trig_a = TRIGA_HIGH;
                n_trig_b = TRIGB_HIGH;
            end else if (v_ph < PHASE_DONE) begin
                n_trig_a = TRIGA_LOW;
                n_trig_b = TRIGB_HIGH;
            end else begin
                n_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_ready     <= 1'b0;
            r_burst     <= '0;
            r_phase     <= '0;
            r_small     <= PWM_MIN;
            r_big       <= PWM_MIN;
            r_feeder    <= PWM_MIN;
            r_gate      <= GATE_RESET;
            r_trig_a    <= TRIGA_HIGH;
            r_trig_b    <= TRIGB_HIGH;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_running   <= n_running;
                r_ready     <= n_ready;
                r_burst     <= n_burst;
                r_phase     <= n_phase;
                r_small     <= n_small;
                r_big       <= n_big;
                r_feeder    <= n_feeder;
                r_gate      <= n_gate;
                r_trig_a    <= n_trig_a;
                r_trig_b    <= n_trig_b;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.small_wheel_pwm = r_small;
    assign o_out.big_wheel_pwm   = r_big;
    assign o_out.feeder_pwm      = r_feeder;
    assign o_out.gate_pwm        = r_gate;
    assign o_out.trigger_a_pwm   = r_trig_a;
    assign o_out.trigger_b_pwm   = r_trig_b;
    assign o_out.ready_flag      = r_ready;
    assign o_out.wheels_running  = r_running;

    a_ready_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_phase >= PHASE_DONE))
        else $error("ready set before trigger sequence finished");

    a_stopped_wheels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_small == PWM_MIN && r_big == PWM_MIN))
        else $error("wheels driven while stopped");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("pending input beat dropped");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_phase) && $stable(r_burst))
        else $error("state moved while result stalled");

endmodule

FILE: tb/sv/launcher_actuator_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// launcher_actuator_sequencer_tb
// Self-checking bench for the launcher actuator sequencer. Switch beats are
// sent through the input channel under random source and sink idling. Each
// accepted beat updates a local model of the friction, feeder, gate and
// trigger state. That model predicts the result beat, and every output beat
// is compared field by field against the oldest prediction. Directed tests
// cover the switch actions, the trigger timing and the register extremes.
// Random phases follow, then a long sink hold-off with input back-pressure.
// ----------------------------------------------------------------------------
module launcher_actuator_sequencer_tb;
    import las_pkg::*;

    localparam int SW_STOP       = 0;
    localparam int SW_SPIN_SMALL = 1;
    localparam int SW_SPIN_LARGE = 2;
    localparam int SW_FEED_OFF   = 3;
    localparam int SW_BURST      = 4;
    localparam int SW_REARM      = 5;
    localparam int HOLD_CYCLES   = 60;

    typedef struct packed {
        logic [PWM_W-1:0]   small_pwm;
        logic [PWM_W-1:0]   big_pwm;
        logic [PWM_W-1:0]   feeder_pwm;
        logic [GATE_W-1:0]  gate_pwm;
        logic [TRIGA_W-1:0] trig_a;
        logic [TRIGB_W-1:0] trig_b;
        logic               ready_flag;
        logic               running;
    } t_pwm_beat;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    las_in_if  in_ch ();
    las_out_if out_ch ();

    launcher_actuator_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model configuration
    logic [PWM_W-1:0] cfg_small;
    logic [PWM_W-1:0] cfg_big;
    logic [PWM_W-1:0] cfg_feed;
    logic [CNT_W-1:0] cfg_period;
    logic [CNT_W-1:0] cfg_on;

    // model state
    logic               wheels_on;
    logic [CNT_W-1:0]   burst_cnt;
    logic [PHASE_W-1:0] phase_cnt;
    logic               seq_done;
    logic [PWM_W-1:0]   hold_small;
    logic [PWM_W-1:0]   hold_big;
    logic [PWM_W-1:0]   hold_feed;
    logic [GATE_W-1:0]  hold_gate;
    logic [TRIGA_W-1:0] hold_trig_a;
    logic [TRIGB_W-1:0] hold_trig_b;

    t_pwm_beat pwm_expect_q[$];
    t_pwm_beat want;
    t_pwm_beat got;
    int        want_f[8];
    int        got_f[8];
    string     field_name[8] = '{"small_wheel_pwm", "big_wheel_pwm", "feeder_pwm",
                                 "gate_pwm", "trigger_a_pwm", "trigger_b_pwm",
                                 "ready_flag", "wheels_running"};
    int        mismatch_count;
    int        src_idle_pct;
    int        sink_idle_pct;
    logic      hold_req;
    logic      hold_seen;
    int        hold_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PWM_W-1:0] limit_speed(input logic [PWM_W-1:0] v);
        if (v < PWM_MIN) begin
            return PWM_MIN;
        end
        if (v > PWM_MAX) begin
            return PWM_MAX;
        end
        return v;
    endfunction

    task automatic reset_model();
        cfg_small   = RST_SMALL_SPD;
        cfg_big     = RST_BIG_SPD;
        cfg_feed    = RST_FEED_ON;
        cfg_period  = RST_BURST_PER;
        cfg_on      = RST_BURST_ON;
        wheels_on   = 1'b0;
        burst_cnt   = '0;
        phase_cnt   = '0;
        seq_done    = 1'b0;
        hold_small  = PWM_MIN;
        hold_big    = PWM_MIN;
        hold_feed   = PWM_MIN;
        hold_gate   = GATE_RESET;
        hold_trig_a = TRIGA_HIGH;
        hold_trig_b = TRIGB_HIGH;
    endtask

    function automatic t_pwm_beat predict_tick(input logic [5:0] sw);
        t_pwm_beat r;
        logic [CNT_W:0] nxt;
        if (sw[SW_STOP]) begin
            hold_small = PWM_MIN;
            hold_big   = PWM_MIN;
            hold_gate  = GATE_SMALL;
            wheels_on  = 1'b0;
        end
        if (sw[SW_SPIN_SMALL]) begin
            hold_small = limit_speed(cfg_small);
            hold_big   = limit_speed(cfg_big);
            hold_gate  = GATE_SMALL;
            wheels_on  = 1'b1;
        end
        if (sw[SW_SPIN_LARGE]) begin
            hold_small = limit_speed(cfg_small);
            hold_big   = limit_speed(cfg_big);
            hold_gate  = GATE_LARGE;
            wheels_on  = 1'b1;
        end
        if (sw[SW_FEED_OFF]) begin
            hold_feed = PWM_MIN;
            burst_cnt = '0;
        end
        if (sw[SW_BURST] && wheels_on) begin
            nxt = {1'b0, burst_cnt} + 1'b1;
            if (nxt > {1'b0, cfg_period}) begin
                nxt = '0;
            end
            burst_cnt = nxt[CNT_W-1:0];
            hold_feed = (burst_cnt < cfg_on) ? limit_speed(cfg_feed) : PWM_MIN;
        end
        if (sw[SW_REARM] && wheels_on && seq_done) begin
            phase_cnt = '0;
            seq_done  = 1'b0;
        end
        if (!seq_done) begin
            phase_cnt = phase_cnt + 1'b1;
            if (phase_cnt == PHASE_LIMIT) begin
                phase_cnt = PHASE_REWIND;
            end
            if (phase_cnt < PHASE_1) begin
                hold_trig_a = TRIGA_LOW;
                hold_trig_b = TRIGB_LOW;
            end else if (phase_cnt < PHASE_2) begin
                hold_trig_a = TRIGA_LOW;
                hold_trig_b = TRIGB_HIGH;
            end else if (phase_cnt < PHASE_3) begin
                hold_trig_a = TRIGA_HIGH;
                hold_trig_b = TRIGB_HIGH;
            end else if (phase_cnt < PHASE_DONE) begin
                hold_trig_a = TRIGA_LOW;
                hold_trig_b = TRIGB_HIGH;
            end else begin
                seq_done = 1'b1;
            end
        end
        r.small_pwm  = hold_small;
        r.big_pwm    = hold_big;
        r.feeder_pwm = hold_feed;
        r.gate_pwm   = hold_gate;
        r.trig_a     = hold_trig_a;
        r.trig_b     = hold_trig_b;
        r.ready_flag = seq_done;
        r.running    = wheels_on;
        return r;
    endfunction

    // result checker and input monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.small_pwm  = out_ch.small_wheel_pwm;
                got.big_pwm    = out_ch.big_wheel_pwm;
                got.feeder_pwm = out_ch.feeder_pwm;
                got.gate_pwm   = out_ch.gate_pwm;
                got.trig_a     = out_ch.trigger_a_pwm;
                got.trig_b     = out_ch.trigger_b_pwm;
                got.ready_flag = out_ch.ready_flag;
                got.running    = out_ch.wheels_running;
                if (pwm_expect_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, actual %p", $time, got);
                end else begin
                    want = pwm_expect_q.pop_front();
                    want_f = '{want.small_pwm, want.big_pwm, want.feeder_pwm, want.gate_pwm,
                               want.trig_a, want.trig_b, want.ready_flag, want.running};
                    got_f  = '{got.small_pwm, got.big_pwm, got.feeder_pwm, got.gate_pwm,
                               got.trig_a, got.trig_b, got.ready_flag, got.running};
                    for (int k = 0; k < 8; k++) begin
                        if (want_f[k] != got_f[k]) begin
                            mismatch_count++;
                            $display("%0t: %s expected %0d actual %0d",
                                     $time, field_name[k], want_f[k], got_f[k]);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pwm_expect_q.push_back(predict_tick({in_ch.rearm_switch,
                    in_ch.feed_burst_switch, in_ch.feed_off_switch,
                    in_ch.spin_large_switch, in_ch.spin_small_switch,
                    in_ch.stop_switch}));
            end
        end
    end

    // sink ready with random idling and an on-request hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_beat(input logic [5:0] sw);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.stop_switch       <= sw[SW_STOP];
        in_ch.spin_small_switch <= sw[SW_SPIN_SMALL];
        in_ch.spin_large_switch <= sw[SW_SPIN_LARGE];
        in_ch.feed_off_switch   <= sw[SW_FEED_OFF];
        in_ch.feed_burst_switch <= sw[SW_BURST];
        in_ch.rearm_switch      <= sw[SW_REARM];
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pwm_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SMALL_SPEED: cfg_small  = data;
            CFG_BIG_SPEED:   cfg_big    = data;
            CFG_FEED_ON:     cfg_feed   = data;
            CFG_BURST_PER:   cfg_period = data[CNT_W-1:0];
            CFG_BURST_ON:    cfg_on     = data[CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [CFG_DW-1:0] s, input logic [CFG_DW-1:0] b,
                           input logic [CFG_DW-1:0] f, input logic [CFG_DW-1:0] p,
                           input logic [CFG_DW-1:0] o);
        cfg_write(CFG_SMALL_SPEED, s);
        cfg_write(CFG_BIG_SPEED, b);
        cfg_write(CFG_FEED_ON, f);
        cfg_write(CFG_BURST_PER, p);
        cfg_write(CFG_BURST_ON, o);
    endtask

    function automatic logic [5:0] random_switches(input int burst_pct, input int off_pct);
        logic [5:0] sw;
        if ($urandom_range(0, 99) < 10) begin
            return 6'($urandom);
        end
        sw[SW_STOP]       = ($urandom_range(0, 99) < 4);
        sw[SW_SPIN_SMALL] = ($urandom_range(0, 99) < 7);
        sw[SW_SPIN_LARGE] = ($urandom_range(0, 99) < 7);
        sw[SW_FEED_OFF]   = ($urandom_range(0, 99) < off_pct);
        sw[SW_BURST]      = ($urandom_range(0, 99) < burst_pct);
        sw[SW_REARM]      = ($urandom_range(0, 99) < 20);
        return sw;
    endfunction

    task automatic test_switch_actions();
        logic [5:0] beats[$] = '{6'b000000, 6'b000010, 6'b010000, 6'b010000, 6'b010000,
                                 6'b001000, 6'b011000, 6'b000100, 6'b000110, 6'b000011,
                                 6'b000001, 6'b010000, 6'b001000, 6'b100000, 6'b111111,
                                 6'b010001, 6'b010100, 6'b100010, 6'b000000};
        foreach (beats[k]) begin
            send_beat(beats[k]);
        end
    endtask

    task automatic test_trigger_cycle();
        send_beat(6'b000010);
        repeat (110) send_beat(6'b000000);
        send_beat(6'b100000);
        repeat (30) send_beat(6'b010000);
        repeat (80) send_beat(6'b000000);
        send_beat(6'b100001);
        send_beat(6'b000100);
        send_beat(6'b100000);
        send_beat(6'b100000);
    endtask

    task automatic test_config_extremes();
        cfg_all(11'd0, 11'h7FF, 11'd999, 11'd0, 11'd0);
        send_beat(6'b000010);
        repeat (4) send_beat(6'b010000);
        cfg_all(11'd1000, 11'd2000, 11'd2001, 11'd1, 11'd1);
        send_beat(6'b000100);
        repeat (5) send_beat(6'b010000);
        cfg_all(11'd2000, 11'd1000, 11'h7FF, 11'h7FF, 11'h7FF);
        send_beat(6'b001010);
        repeat (12) send_beat(6'b010000);
        cfg_all(11'd2047, 11'd0, 11'd1000, 11'd255, 11'd0);
        send_beat(6'b000010);
        repeat (5) send_beat(6'b010000);
    endtask

    task automatic test_random_phase(input int n, input int burst_pct, input int off_pct);
        cfg_all(11'($urandom), 11'($urandom_range(900, 2100)), 11'($urandom_range(900, 2100)),
                11'($urandom_range(0, 40)), 11'($urandom_range(0, 30)));
        repeat (n) send_beat(random_switches(burst_pct, off_pct));
    endtask

    task automatic test_backpressure();
        hold_req = ~hold_req;
        repeat (40) send_beat(random_switches(60, 5));
        wait_drain();
        repeat (20) send_beat(random_switches(60, 5));
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_SMALL_SPEED;
        i_cfg_data     = '0;
        in_ch.valid             = 1'b0;
        in_ch.stop_switch       = 1'b0;
        in_ch.spin_small_switch = 1'b0;
        in_ch.spin_large_switch = 1'b0;
        in_ch.feed_off_switch   = 1'b0;
        in_ch.feed_burst_switch = 1'b0;
        in_ch.rearm_switch      = 1'b0;
        out_ch.ready   = 1'b0;
        mismatch_count = 0;
        src_idle_pct   = 31;
        sink_idle_pct  = 69;
        hold_req       = 1'b0;
        hold_seen      = 1'b0;
        hold_left      = 0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_switch_actions();
        test_trigger_cycle();
        test_config_extremes();

        test_random_phase(80, 60, 5);
        src_idle_pct  = 69;
        sink_idle_pct = 31;
        test_random_phase(80, 85, 1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_phase(80, 40, 10);
        test_backpressure();
        cfg_all(RST_SMALL_SPD, RST_BIG_SPD, RST_FEED_ON, RST_BURST_PER, RST_BURST_ON);
        repeat (20) send_beat(random_switches(60, 5));

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (pwm_expect_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d result beats never arrived", $time, pwm_expect_q.size());
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: launcher_actuator_sequencer.f
rtl/las_pkg.sv
rtl/las_ifs.sv
rtl/launcher_actuator_sequencer.sv
tb/sv/launcher_actuator_sequencer_tb.sv
